// ----- design/tofmw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofmw_pkg
// Shared types, register indexes and the quarter-wave cosine table for the
// time-of-flight modulation weight pipeline.
// ----------------------------------------------------------------------------
package tofmw_pkg;

  localparam int unsigned WAVE_LUT_BITS = 10;
  localparam int unsigned QUAD_BITS     = WAVE_LUT_BITS - 2;
  localparam int unsigned QUAD_SIZE     = 1 << QUAD_BITS;

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OFFS_W  = 16;
  localparam int unsigned WAVE_W  = 17;  // Q15 plus room for +1.0
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  // 2*pi in Q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam int unsigned TAYLOR_TERMS = 10;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_TRI    = 2'd2,
    WAVE_SINE3  = 2'd3
  } wave_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_ILLUM_RATE   = 3'd0,
    CFG_BEAT_RATE    = 3'd1,
    CFG_LENGTH_RATE  = 3'd2,
    CFG_SENSOR_PHASE = 3'd3,
    CFG_ILLUM_WAVE   = 3'd4,
    CFG_SENSOR_WAVE  = 3'd5,
    CFG_LOW_FREQ     = 3'd6
  } cfg_idx_e;

  typedef logic [WAVE_W-1:0] cos_val_t;
  typedef cos_val_t cos_lut_t [QUAD_SIZE];

  // Restoring shift-subtract quotient, used while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // First-quadrant cosine of 2*pi*m/2^WAVE_LUT_BITS, Taylor series in Q30,
  // clamped to [0, 1.0] and rounded half up to Q15. Elaboration only.
  function automatic cos_val_t quad_cos(input logic [63:0] m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        div;
    logic signed [63:0] sum;
    logic [63:0]        usum;
    x    = (m * TWO_PI_Q30) >> WAVE_LUT_BITS;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = $signed(term);
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      div  = 64'((2 * n - 1) * (2 * n));
      term = udiv64((term * x2) >> 30, div);
      if ((n % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    usum = $unsigned(sum) + 64'd16384;
    return cos_val_t'(usum >> 15);
  endfunction

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t lut;
    for (int i = 0; i < QUAD_SIZE; i++) begin
      lut[i] = quad_cos(64'(i));
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT      = build_cos_lut();
  // value at the quarter-turn point, just past the table
  localparam cos_val_t COS_QUAD_END = quad_cos(64'(QUAD_SIZE));

endpackage

// ----- design/tof_modulation_weight.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_modulation_weight
// Time-of-flight correlation weight from a sample time and a path length.
// ----------------------------------------------------------------------------
// Pipeline: a request taken shows on weight_o with valid_o high after passing
//   five register stages: phase multiply, phase sum, waveform lookup,
//   mix multiply, round and saturate.
// Throughput: one request per cycle; busy is never raised and the result
//   strobe cannot be held off.
// Reset: clears the stage valid bits and the config registers (not the stage data);
//   low_freq_q resets to 1, all other config registers to 0.
module tof_modulation_weight (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tofmw_pkg::IN_W-1:0]           sample_time_i,
  input  logic [tofmw_pkg::IN_W-1:0]           path_len_i,
  input  logic                                 cfg_we_i,
  input  logic [tofmw_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [tofmw_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                 valid_o,
  output logic signed [tofmw_pkg::OUT_W-1:0]   weight_o
);

  localparam int unsigned PW   = tofmw_pkg::PHASE_W;
  localparam int unsigned WW   = tofmw_pkg::WAVE_W;
  localparam int unsigned QB   = tofmw_pkg::QUAD_BITS;
  localparam int unsigned LB   = tofmw_pkg::WAVE_LUT_BITS;
  localparam int unsigned PRW  = 2 * WW + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PW-1:0]                   illum_rate_q;
  logic [PW-1:0]                   beat_rate_q;
  logic [PW-1:0]                   length_rate_q;
  logic [tofmw_pkg::OFFS_W-1:0]    sensor_phase_q;
  tofmw_pkg::wave_e                illum_wave_q;
  tofmw_pkg::wave_e                sensor_wave_q;
  logic                            low_freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      illum_rate_q   <= '0;
      beat_rate_q    <= '0;
      length_rate_q  <= '0;
      sensor_phase_q <= '0;
      illum_wave_q   <= tofmw_pkg::WAVE_SINE;
      sensor_wave_q  <= tofmw_pkg::WAVE_SINE;
      low_freq_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (tofmw_pkg::cfg_idx_e'(cfg_idx_i))
        tofmw_pkg::CFG_ILLUM_RATE:   illum_rate_q   <= cfg_data_i[PW-1:0];
        tofmw_pkg::CFG_BEAT_RATE:    beat_rate_q    <= cfg_data_i[PW-1:0];
        tofmw_pkg::CFG_LENGTH_RATE:  length_rate_q  <= cfg_data_i[PW-1:0];
        tofmw_pkg::CFG_SENSOR_PHASE: sensor_phase_q <= cfg_data_i[tofmw_pkg::OFFS_W-1:0];
        tofmw_pkg::CFG_ILLUM_WAVE:   illum_wave_q   <= tofmw_pkg::wave_e'(cfg_data_i[1:0]);
        tofmw_pkg::CFG_SENSOR_WAVE:  sensor_wave_q  <= tofmw_pkg::wave_e'(cfg_data_i[1:0]);
        tofmw_pkg::CFG_LOW_FREQ:     low_freq_q     <= cfg_data_i[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Waveform evaluation, Q15 with +1.0 representable
  // --------------------------------------------------------------------------
  function automatic logic signed [WW-1:0] wave_eval(input logic [PW-1:0] p,
                                                     input tofmw_pkg::wave_e kind);
    logic [LB-1:0]          k;
    logic [QB-1:0]          j;
    logic [QB-1:0]          jn;
    logic [WW-1:0]          mag;
    logic                   neg;
    logic signed [WW:0]     v;
    logic signed [WW:0]     tri_val;
    logic signed [WW-1:0]   res;
    k   = p[PW-1 -: LB];
    j   = k[QB-1:0];
    jn  = QB'(~j + 1'b1);
    mag = '0;
    neg = 1'b0;
    v   = $signed({1'b0, p[PW-1:15]});
    unique case (kind)
      tofmw_pkg::WAVE_SQUARE: begin
        if (p >= 32'h4000_0000 && p <= 32'hC000_0000) begin
          res = -(WW)'(32768);
        end else begin
          res = (WW)'(32768);
        end
      end
      tofmw_pkg::WAVE_TRI: begin
        if (!p[PW-1]) begin
          tri_val = (WW+1)'(32768) - v;
        end else begin
          tri_val = v - (WW+1)'(98304);
        end
        res = tri_val[WW-1:0];
      end
      default: begin
        // fold the turn onto the first quadrant
        unique case (k[LB-1:LB-2])
          2'd0: begin
            mag = tofmw_pkg::COS_LUT[j];
          end
          2'd1: begin
            mag = (j == '0) ? tofmw_pkg::COS_QUAD_END : tofmw_pkg::COS_LUT[jn];
            neg = 1'b1;
          end
          2'd2: begin
            mag = tofmw_pkg::COS_LUT[j];
            neg = 1'b1;
          end
          default: begin
            mag = (j == '0) ? tofmw_pkg::COS_QUAD_END : tofmw_pkg::COS_LUT[jn];
          end
        endcase
        res = neg ? -$signed(mag) : $signed(mag);
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stage 1: phase products
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic          s1_lf_q;
  logic [PW-1:0] s1_beat_t_q;
  logic [PW-1:0] s1_illum_t_q;
  logic [PW-1:0] s1_path_q;
  logic          accept;

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lf_q      <= low_freq_q;
      s1_beat_t_q  <= PW'(beat_rate_q * PW'(sample_time_i));
      s1_illum_t_q <= PW'(illum_rate_q * PW'(sample_time_i));
      s1_path_q    <= PW'(length_rate_q * PW'(path_len_i));
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: phase sums
  // --------------------------------------------------------------------------
  logic          s2_valid_q;
  logic          s2_lf_q;
  logic [PW-1:0] s2_phase_a_q;
  logic [PW-1:0] s2_phase_b_q;
  logic [PW-1:0] offs;
  logic [PW-1:0] beat_ph;
  logic [PW-1:0] illum_ph;

  assign offs     = {sensor_phase_q, 16'h0000};
  assign beat_ph  = s1_beat_t_q + offs + s1_path_q;
  assign illum_ph = s1_illum_t_q - s1_path_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_lf_q      <= s1_lf_q;
      s2_phase_a_q <= s1_lf_q ? beat_ph : illum_ph;
      // sensor phase: (illum + beat) * t + offset, summed from the products
      s2_phase_b_q <= s1_illum_t_q + s1_beat_t_q + offs;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: waveforms
  // --------------------------------------------------------------------------
  logic                 s3_valid_q;
  logic                 s3_lf_q;
  logic signed [WW-1:0] s3_wave_a_q;
  logic signed [WW-1:0] s3_wave_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_lf_q     <= s2_lf_q;
      s3_wave_a_q <= wave_eval(s2_phase_a_q,
                               s2_lf_q ? tofmw_pkg::WAVE_SINE : illum_wave_q);
      s3_wave_b_q <= wave_eval(s2_phase_b_q, sensor_wave_q);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: mix product, low-frequency quarter cosine
  // --------------------------------------------------------------------------
  localparam int unsigned   OUT_W_L = tofmw_pkg::OUT_W;
  logic                     s4_valid_q;
  logic                     s4_lf_q;
  logic signed [PRW-1:0]    s4_prod_q;
  logic signed [OUT_W_L-1:0] s4_lf_w_q;
  logic signed [WW:0]       wi_off;
  logic [WW:0]              lf_sum;
  logic signed [OUT_W_L-1:0] lf_w;

  assign wi_off = (WW+1)'(s3_wave_a_q) + (WW+1)'(32768);
  assign lf_sum = (WW+1)'(s3_wave_a_q) + (WW+1)'(32770);
  assign lf_w   = $signed(OUT_W_L'(lf_sum[WW:2])) - OUT_W_L'(8192);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      s4_lf_q   <= s3_lf_q;
      s4_prod_q <= PRW'(wi_off * s3_wave_b_q);
      s4_lf_w_q <= lf_w;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: round, saturate, output
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0]     rnd_sum;
  logic signed [PRW-17:0]    rnd;
  logic signed [OUT_W_L-1:0] full_w;
  logic                      valid_q;
  logic signed [OUT_W_L-1:0] weight_q;

  assign rnd_sum = s4_prod_q + PRW'(32768);
  assign rnd     = rnd_sum[PRW-1:16];
  assign full_w  = (rnd > (PRW-16)'(32767)) ? OUT_W_L'(32767) : OUT_W_L'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q) begin
      weight_q <= s4_lf_q ? s4_lf_w_q : full_w;
    end
  end

  assign valid_o  = valid_q;
  assign weight_o = weight_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 valid_o)
    else $error("request did not reach the output after five cycles");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 5))
    else $error("result strobe without a matching request");

  a_wave_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_wave_a_q >= -(WW)'(32768) && s3_wave_a_q <= (WW)'(32768) &&
                    s3_wave_b_q >= -(WW)'(32768) && s3_wave_b_q <= (WW)'(32768)))
    else $error("waveform value outside plus or minus one");

  a_lf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && s4_lf_q) |=> (weight_o >= -OUT_W_L'(8192) &&
                                 weight_o <= OUT_W_L'(8192)))
    else $error("low-frequency weight outside a quarter amplitude");

endmodule
